/* rtl/assert_macros.svh */
// Assertion macros for the checker file of the terminal block.
// Depends on nothing; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication under reset
`define STT_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("terminal assertion failed");

// Next-cycle implication under reset
`define STT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("terminal assertion failed");

`endif

/* rtl/stt_pkg.sv */
// Shared types and constants of the scrolling text terminal.
// Depends on nothing; every other file but assert_macros.svh imports it.
package stt_pkg;

    localparam int CHAR_W  = 7;
    localparam int CMD_W   = 2;
    localparam int BLINK_W = 16;
    localparam int NL_W    = 2;
    localparam int CFG_W   = 16;

    // Command codes of an input word
    typedef enum logic [CMD_W-1:0] {
        CMD_WRITE = 2'd0,
        CMD_TICK  = 2'd1,
        CMD_CLEAR = 2'd2,
        CMD_READ  = 2'd3
    } cmd_t;

    // Configuration register indexes
    typedef enum logic [0:0] {
        REG_BLINK_PERIOD  = 1'b0,
        REG_NEWLINE_LIMIT = 1'b1
    } reg_idx_t;

    // Character codes
    localparam logic [CHAR_W-1:0] CHAR_SPACE = 7'h20;
    localparam logic [CHAR_W-1:0] CHAR_DEL   = 7'h7F;
    localparam logic [CHAR_W-1:0] CHAR_CR    = 7'h0D;
    localparam logic [CHAR_W-1:0] CHAR_LF    = 7'h0A;

    // Reset values of the configuration registers
    localparam logic [BLINK_W-1:0] BLINK_PERIOD_RST  = 16'd500;
    localparam logic [NL_W-1:0]    NEWLINE_LIMIT_RST = 2'd2;

endpackage

/* rtl/stt_if.sv */
// Valid/ready channel interfaces for command words and result words.
// Depends on stt_pkg.
interface stt_cmd_if #(
    parameter int SCREEN_ROWS = 24,
    parameter int SCREEN_COLS = 40
);
    import stt_pkg::*;

    localparam int ROW_W = $clog2(SCREEN_ROWS);
    localparam int COL_W = $clog2(SCREEN_COLS + 1);

    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  command;
    logic [CHAR_W-1:0] char_code;
    logic [ROW_W-1:0]  read_row;
    logic [COL_W-1:0]  read_col;

    modport source (output valid, command, char_code, read_row, read_col, input ready);
    modport sink   (input valid, command, char_code, read_row, read_col, output ready);
endinterface

interface stt_res_if #(
    parameter int SCREEN_ROWS = 24,
    parameter int SCREEN_COLS = 40
);
    import stt_pkg::*;

    localparam int ROW_W = $clog2(SCREEN_ROWS);
    localparam int COL_W = $clog2(SCREEN_COLS + 1);

    logic              valid;
    logic              ready;
    logic              echo_valid;
    logic [CHAR_W-1:0] echo_char;
    logic              cell_valid;
    logic [ROW_W-1:0]  cell_row;
    logic [COL_W-1:0]  cell_col;
    logic [CHAR_W-1:0] cell_char;
    logic              scrolled;
    logic              cursor_visible;
    logic [ROW_W-1:0]  cursor_row;
    logic [COL_W-1:0]  cursor_col;
    logic [CHAR_W-1:0] read_char;

    modport source (
        output valid, echo_valid, echo_char, cell_valid, cell_row, cell_col, cell_char,
               scrolled, cursor_visible, cursor_row, cursor_col, read_char,
        input  ready
    );
    modport sink (
        input  valid, echo_valid, echo_char, cell_valid, cell_row, cell_col, cell_char,
               scrolled, cursor_visible, cursor_row, cursor_col, read_char,
        output ready
    );
endinterface

/* rtl/scrolling_text_terminal.sv */
// Scrolling text terminal top level: input register, state logic, result register.
// Depends on stt_pkg, stt_if, stt_state and stt_screen.
//
//   Channel   Dir   Handshake          Carries
//   cmd       in    valid/ready        command, char_code, read_row, read_col
//   res       out   valid/ready        echo, stored cell, scroll, cursor, read_char
//   cfg       in    cfg_we (no stall)  blink_period, newline_limit
//
// One word per cycle sustained while res is ready; a taken word passes the input register, then the result register.
// Scroll and clear move no stored characters: a ring row pointer, per-row valid bits and per-row
// fill lengths stand in for moving or blanking the screen store, so no clearing pass follows reset.
// A stalled result holds; the input register still takes one word behind it.
// Reset is asynchronous, active low.
module scrolling_text_terminal #(
    parameter int SCREEN_ROWS = 24,
    parameter int SCREEN_COLS = 40
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  stt_pkg::reg_idx_t         cfg_index,
    input  logic [stt_pkg::CFG_W-1:0] cfg_data,
    stt_cmd_if.sink                   cmd,
    stt_res_if.source                 res
);
    import stt_pkg::*;

    localparam int ROW_W = $clog2(SCREEN_ROWS);
    localparam int COL_W = $clog2(SCREEN_COLS + 1);
    localparam int CA_W  = $clog2(SCREEN_COLS);

    // Input register
    logic              s1_valid_reg;
    logic [CMD_W-1:0]  s1_cmd_reg;
    logic [CHAR_W-1:0] s1_char_reg;
    logic [ROW_W-1:0]  s1_row_reg;
    logic [COL_W-1:0]  s1_col_reg;

    // Result register
    logic              res_valid_reg;
    logic              echo_valid_reg;
    logic [CHAR_W-1:0] echo_char_reg;
    logic              cell_valid_reg;
    logic [ROW_W-1:0]  cell_row_reg;
    logic [COL_W-1:0]  cell_col_reg;
    logic [CHAR_W-1:0] cell_char_reg;
    logic              scrolled_reg;
    logic              cursor_visible_reg;
    logic [ROW_W-1:0]  cursor_row_reg;
    logic [COL_W-1:0]  cursor_col_reg;

    logic advance;
    logic fire;
    logic take;

    logic              echo_valid_next;
    logic [CHAR_W-1:0] echo_char_next;
    logic              cell_valid_next;
    logic [ROW_W-1:0]  cell_row_next;
    logic [COL_W-1:0]  cell_col_next;
    logic [CHAR_W-1:0] cell_char_next;
    logic              scrolled_next;
    logic              cursor_visible_next;
    logic [ROW_W-1:0]  cursor_row_next;
    logic [COL_W-1:0]  cursor_col_next;
    logic              mem_we;
    logic [ROW_W-1:0]  mem_row;
    logic [CA_W-1:0]   mem_col;
    logic              rd_ok;
    logic              rd_row_valid;
    logic [ROW_W-1:0]  rd_phys;

    // Pipeline control
    assign advance   = !res_valid_reg || res.ready;
    assign fire      = s1_valid_reg && advance;
    assign cmd.ready = !s1_valid_reg || advance;
    assign take      = cmd.valid && cmd.ready;

    // Hold or load the input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (take)
            s1_valid_reg <= 1'b1;
        else if (fire)
            s1_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            s1_cmd_reg  <= cmd.command;
            s1_char_reg <= cmd.char_code;
            s1_row_reg  <= cmd.read_row;
            s1_col_reg  <= cmd.read_col;
        end
    end

    stt_state #(
        .SCREEN_ROWS (SCREEN_ROWS),
        .SCREEN_COLS (SCREEN_COLS)
    ) u_state (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .fire           (fire),
        .command        (s1_cmd_reg),
        .char_code      (s1_char_reg),
        .read_row       (s1_row_reg),
        .read_col       (s1_col_reg),
        .echo_valid     (echo_valid_next),
        .echo_char      (echo_char_next),
        .cell_valid     (cell_valid_next),
        .cell_row       (cell_row_next),
        .cell_col       (cell_col_next),
        .cell_char      (cell_char_next),
        .scrolled       (scrolled_next),
        .cursor_visible (cursor_visible_next),
        .cursor_row     (cursor_row_next),
        .cursor_col     (cursor_col_next),
        .mem_we         (mem_we),
        .mem_row        (mem_row),
        .mem_col        (mem_col),
        .rd_ok          (rd_ok),
        .rd_row_valid   (rd_row_valid),
        .rd_phys        (rd_phys)
    );

    stt_screen #(
        .SCREEN_ROWS (SCREEN_ROWS),
        .SCREEN_COLS (SCREEN_COLS)
    ) u_screen (
        .clk          (clk),
        .rst_n        (rst_n),
        .fire         (fire),
        .wr_en        (mem_we),
        .wr_row       (mem_row),
        .wr_col       (mem_col),
        .wr_char      (cell_char_next),
        .rd_ok        (rd_ok),
        .rd_row_valid (rd_row_valid),
        .rd_row       (rd_phys),
        .rd_col       (s1_col_reg),
        .read_char    (res.read_char)
    );

    // Advance the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else if (advance)
            res_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            echo_valid_reg     <= echo_valid_next;
            echo_char_reg      <= echo_char_next;
            cell_valid_reg     <= cell_valid_next;
            cell_row_reg       <= cell_row_next;
            cell_col_reg       <= cell_col_next;
            cell_char_reg      <= cell_char_next;
            scrolled_reg       <= scrolled_next;
            cursor_visible_reg <= cursor_visible_next;
            cursor_row_reg     <= cursor_row_next;
            cursor_col_reg     <= cursor_col_next;
        end
    end

    assign res.valid          = res_valid_reg;
    assign res.echo_valid     = echo_valid_reg;
    assign res.echo_char      = echo_char_reg;
    assign res.cell_valid     = cell_valid_reg;
    assign res.cell_row       = cell_row_reg;
    assign res.cell_col       = cell_col_reg;
    assign res.cell_char      = cell_char_reg;
    assign res.scrolled       = scrolled_reg;
    assign res.cursor_visible = cursor_visible_reg;
    assign res.cursor_row     = cursor_row_reg;
    assign res.cursor_col     = cursor_col_reg;

endmodule

/* rtl/stt_state.sv */
// Cursor, newline filter, blink timer, ring row pointer and row valid bits.
// Computes one word's results combinationally; depends on stt_pkg.
module stt_state #(
    parameter int SCREEN_ROWS = 24,
    parameter int SCREEN_COLS = 40
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  stt_pkg::reg_idx_t                     cfg_index,
    input  logic [stt_pkg::CFG_W-1:0]             cfg_data,
    input  logic                                  fire,
    input  logic [stt_pkg::CMD_W-1:0]             command,
    input  logic [stt_pkg::CHAR_W-1:0]            char_code,
    input  logic [$clog2(SCREEN_ROWS)-1:0]        read_row,
    input  logic [$clog2(SCREEN_COLS+1)-1:0]      read_col,
    output logic                                  echo_valid,
    output logic [stt_pkg::CHAR_W-1:0]            echo_char,
    output logic                                  cell_valid,
    output logic [$clog2(SCREEN_ROWS)-1:0]        cell_row,
    output logic [$clog2(SCREEN_COLS+1)-1:0]      cell_col,
    output logic [stt_pkg::CHAR_W-1:0]            cell_char,
    output logic                                  scrolled,
    output logic                                  cursor_visible,
    output logic [$clog2(SCREEN_ROWS)-1:0]        cursor_row,
    output logic [$clog2(SCREEN_COLS+1)-1:0]      cursor_col,
    output logic                                  mem_we,
    output logic [$clog2(SCREEN_ROWS)-1:0]        mem_row,
    output logic [$clog2(SCREEN_COLS)-1:0]        mem_col,
    output logic                                  rd_ok,
    output logic                                  rd_row_valid,
    output logic [$clog2(SCREEN_ROWS)-1:0]        rd_phys
);
    import stt_pkg::*;

    localparam int ROW_W = $clog2(SCREEN_ROWS);
    localparam int COL_W = $clog2(SCREEN_COLS + 1);
    localparam int CA_W  = $clog2(SCREEN_COLS);
    localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(SCREEN_ROWS - 1);
    localparam logic [ROW_W:0]   ROWS_C   = (ROW_W+1)'(SCREEN_ROWS);
    localparam logic [COL_W-1:0] COLS_C   = COL_W'(SCREEN_COLS);

    // Configuration
    logic [BLINK_W-1:0] period_reg;
    logic [NL_W-1:0]    nl_limit_reg;

    // Terminal state
    logic [ROW_W-1:0]       row_reg, row_next;
    logic [COL_W-1:0]       col_reg, col_next;
    logic [NL_W-1:0]        nl_run_reg, nl_run_next;
    logic                   cursor_on_reg, cursor_on_next;
    logic [BLINK_W-1:0]     blink_reg, blink_next;
    logic [ROW_W-1:0]       top_reg, top_next;
    logic [SCREEN_ROWS-1:0] row_valid_reg, row_valid_next;

    logic [CHAR_W-1:0]  ch;
    logic               keep;
    logic               is_nl;
    logic               adv_row;
    logic [COL_W-1:0]   t_col;
    logic [ROW_W-1:0]   top_plus;
    logic [BLINK_W-1:0] blink_sum;

    // Map a screen row to its storage row through the ring pointer
    function automatic logic [ROW_W-1:0] phys_row(
        input logic [ROW_W-1:0] top,
        input logic [ROW_W-1:0] r
    );
        logic [ROW_W:0] s;
        s = {1'b0, top} + {1'b0, r};
        if (s >= ROWS_C)
            s = s - ROWS_C;
        return s[ROW_W-1:0];
    endfunction

    assign top_plus  = (top_reg == LAST_ROW) ? '0 : top_reg + ROW_W'(1);
    assign blink_sum = blink_reg + BLINK_W'(1);

    // Read lookup
    assign rd_ok = (cmd_t'(command) == CMD_READ) && ({1'b0, read_row} < ROWS_C)
                   && (read_col < COLS_C);
    assign rd_phys      = phys_row(top_reg, read_row);
    assign rd_row_valid = rd_ok && row_valid_reg[rd_phys];

    // Work out the next state and the result of one word
    always_comb
    begin
        row_next       = row_reg;
        col_next       = col_reg;
        nl_run_next    = nl_run_reg;
        cursor_on_next = cursor_on_reg;
        blink_next     = blink_reg;
        top_next       = top_reg;
        row_valid_next = row_valid_reg;
        echo_valid     = 1'b0;
        echo_char      = '0;
        cell_valid     = 1'b0;
        cell_row       = '0;
        cell_col       = '0;
        cell_char      = '0;
        scrolled       = 1'b0;
        mem_we         = 1'b0;
        mem_row        = '0;
        mem_col        = '0;
        ch             = char_code;
        keep           = 1'b0;
        is_nl          = 1'b0;
        adv_row        = 1'b0;
        t_col          = '0;

        case (cmd_t'(command))
            CMD_WRITE:
            begin
                cursor_on_next = 1'b0;
                // drop DEL and control codes other than CR and LF
                keep = !(ch == CHAR_DEL ||
                         (ch < CHAR_SPACE && ch != CHAR_CR && ch != CHAR_LF));
                if (ch == CHAR_CR)
                    ch = CHAR_LF;
                is_nl = (ch == CHAR_LF);
                // limit runs of newlines
                if (keep)
                begin
                    if (is_nl)
                    begin
                        if (nl_run_reg >= nl_limit_reg)
                            keep = 1'b0;
                        else
                            nl_run_next = nl_run_reg + NL_W'(1);
                    end
                    else
                        nl_run_next = '0;
                end
                // advance a row on newline or pending wrap, scroll at the bottom
                adv_row = keep && (is_nl || col_reg >= COLS_C);
                if (adv_row)
                begin
                    col_next = '0;
                    if (row_reg == LAST_ROW)
                    begin
                        scrolled               = 1'b1;
                        top_next               = top_plus;
                        row_valid_next[top_reg] = 1'b0;
                    end
                    else
                        row_next = row_reg + ROW_W'(1);
                end
                if (keep)
                begin
                    echo_valid = 1'b1;
                    echo_char  = ch;
                end
                // store a printable character
                if (keep && !is_nl)
                begin
                    t_col      = adv_row ? '0 : col_reg;
                    mem_row    = scrolled ? top_reg : phys_row(top_reg, row_next);
                    mem_col    = t_col[CA_W-1:0];
                    mem_we     = 1'b1;
                    cell_valid = 1'b1;
                    cell_row   = row_next;
                    cell_col   = t_col;
                    cell_char  = ch;
                    col_next   = t_col + COL_W'(1);
                    row_valid_next[mem_row] = 1'b1;
                end
            end
            CMD_TICK:
            begin
                if (blink_sum >= period_reg)
                begin
                    blink_next     = '0;
                    cursor_on_next = !cursor_on_reg;
                end
                else
                    blink_next = blink_sum;
            end
            CMD_CLEAR:
            begin
                row_next       = '0;
                col_next       = '0;
                row_valid_next = '0;
            end
            default:
            begin
                // read: no state change
            end
        endcase
    end

    assign cursor_visible = cursor_on_next;
    assign cursor_row     = row_next;
    assign cursor_col     = col_next;

    // Hold configuration and advance state on each processed word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg    <= BLINK_PERIOD_RST;
            nl_limit_reg  <= NEWLINE_LIMIT_RST;
            row_reg       <= '0;
            col_reg       <= '0;
            nl_run_reg    <= '0;
            cursor_on_reg <= 1'b0;
            blink_reg     <= '0;
            top_reg       <= '0;
            row_valid_reg <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_BLINK_PERIOD:  period_reg   <= cfg_data[BLINK_W-1:0];
                    REG_NEWLINE_LIMIT: nl_limit_reg <= cfg_data[NL_W-1:0];
                    default:           period_reg   <= period_reg;
                endcase
            end
            if (fire)
            begin
                row_reg       <= row_next;
                col_reg       <= col_next;
                nl_run_reg    <= nl_run_next;
                cursor_on_reg <= cursor_on_next;
                blink_reg     <= blink_next;
                top_reg       <= top_next;
                row_valid_reg <= row_valid_next;
            end
        end
    end

endmodule

/* rtl/stt_screen.sv */
// Screen character store and per-row fill lengths, with registered reads.
// Depends on stt_pkg.
module stt_screen #(
    parameter int SCREEN_ROWS = 24,
    parameter int SCREEN_COLS = 40
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             fire,
    input  logic                             wr_en,
    input  logic [$clog2(SCREEN_ROWS)-1:0]   wr_row,
    input  logic [$clog2(SCREEN_COLS)-1:0]   wr_col,
    input  logic [stt_pkg::CHAR_W-1:0]       wr_char,
    input  logic                             rd_ok,
    input  logic                             rd_row_valid,
    input  logic [$clog2(SCREEN_ROWS)-1:0]   rd_row,
    input  logic [$clog2(SCREEN_COLS+1)-1:0] rd_col,
    output logic [stt_pkg::CHAR_W-1:0]       read_char
);
    import stt_pkg::*;

    localparam int ROW_W     = $clog2(SCREEN_ROWS);
    localparam int COL_W     = $clog2(SCREEN_COLS + 1);
    localparam int CA_W      = $clog2(SCREEN_COLS);
    localparam int MEM_DEPTH = SCREEN_ROWS << CA_W;

    logic [CHAR_W-1:0] char_mem [MEM_DEPTH];
    logic [COL_W-1:0]  len_mem  [SCREEN_ROWS];

    logic [COL_W-1:0]  len_data;
    logic [CHAR_W-1:0] rd_char_reg;
    logic [COL_W-1:0]  rd_len_reg;
    logic [COL_W-1:0]  rd_col_reg;
    logic              rd_ok_reg;
    logic              rd_valid_reg;

    assign len_data = COL_W'(wr_col) + COL_W'(1);

    // Write the character and set the row's fill length just past it
    always_ff @(posedge clk)
    begin
        if (fire && wr_en)
        begin
            char_mem[{wr_row, wr_col}] <= wr_char;
            len_mem[wr_row]            <= len_data;
        end
    end

    // Register the read data
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            rd_char_reg <= char_mem[{rd_row, rd_col[CA_W-1:0]}];
            rd_len_reg  <= len_mem[rd_row];
            rd_col_reg  <= rd_col;
        end
    end

    // Hold read qualifiers with the read data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ok_reg    <= 1'b0;
            rd_valid_reg <= 1'b0;
        end
        else if (fire)
        begin
            rd_ok_reg    <= rd_ok;
            rd_valid_reg <= rd_row_valid;
        end
    end

    // Out-of-range reads give zero; cells past the fill length, or in a blanked row, read as spaces
    always_comb
    begin
        if (!rd_ok_reg)
            read_char = '0;
        else if (rd_valid_reg && rd_col_reg < rd_len_reg)
            read_char = rd_char_reg;
        else
            read_char = CHAR_SPACE;
    end

endmodule

/* rtl/stt_checker.sv */
// Port-level checks on the terminal's result channel, bound to the top level.
// Depends on stt_pkg and assert_macros.svh.
`include "assert_macros.svh"

module stt_checker #(
    parameter int SCREEN_ROWS = 24,
    parameter int SCREEN_COLS = 40
) (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             res_valid,
    input logic                             res_ready,
    input logic                             echo_valid,
    input logic [stt_pkg::CHAR_W-1:0]       echo_char,
    input logic                             cell_valid,
    input logic [$clog2(SCREEN_ROWS)-1:0]   cell_row,
    input logic [$clog2(SCREEN_COLS+1)-1:0] cell_col,
    input logic [stt_pkg::CHAR_W-1:0]       cell_char,
    input logic                             scrolled,
    input logic [$clog2(SCREEN_ROWS)-1:0]   cursor_row,
    input logic [$clog2(SCREEN_COLS+1)-1:0] cursor_col
);
    import stt_pkg::*;

    localparam int ROW_W = $clog2(SCREEN_ROWS);
    localparam int COL_W = $clog2(SCREEN_COLS + 1);
    localparam logic [ROW_W:0]   ROWS_C = (ROW_W+1)'(SCREEN_ROWS);
    localparam logic [COL_W-1:0] COLS_C = COL_W'(SCREEN_COLS);

    logic                          res_stall;
    logic                          res_store;
    logic                          res_quiet;
    logic [ROW_W+COL_W+CHAR_W-1:0] held_fields;
    logic                          cursor_past_store;
    logic                          cursor_in_range;

    assign res_stall         = res_valid && !res_ready;
    assign res_store         = res_valid && cell_valid;
    assign res_quiet         = res_valid && !echo_valid;
    assign held_fields       = {cursor_row, cursor_col, echo_char};
    assign cursor_past_store = (cursor_row == cell_row) && (cursor_col == cell_col + COL_W'(1));
    assign cursor_in_range   = ({1'b0, cursor_row} < ROWS_C) && (cursor_col <= COLS_C);

    // Stalled result word stays valid and holds its cursor and echo fields
    `STT_ASSERT_NEXT(a_res_hold, clk, rst_n, res_stall, res_valid && $stable(held_fields))

    // Stored character leaves the cursor just past it
    `STT_ASSERT_IMP(a_cursor_after_store, clk, rst_n, res_store, cursor_past_store)

    // A store is always echoed with the same character
    `STT_ASSERT_IMP(a_store_echoed, clk, rst_n, res_store, echo_valid && echo_char == cell_char)

    // No echo means no store, no scroll and a zero echo field
    `STT_ASSERT_IMP(a_quiet_word, clk, rst_n, res_quiet, echo_char == '0 && !cell_valid && !scrolled)

    // Cursor row stays on the screen; the column may sit one past the last
    `STT_ASSERT_IMP(a_cursor_range, clk, rst_n, res_valid, cursor_in_range)

endmodule

bind scrolling_text_terminal stt_checker #(
    .SCREEN_ROWS (SCREEN_ROWS),
    .SCREEN_COLS (SCREEN_COLS)
) u_stt_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .res_valid  (res.valid),
    .res_ready  (res.ready),
    .echo_valid (res.echo_valid),
    .echo_char  (res.echo_char),
    .cell_valid (res.cell_valid),
    .cell_row   (res.cell_row),
    .cell_col   (res.cell_col),
    .cell_char  (res.cell_char),
    .scrolled   (res.scrolled),
    .cursor_row (res.cursor_row),
    .cursor_col (res.cursor_col)
);

/* bench/scrolling_text_terminal_test.sv */
// Self-checking bench for the scrolling text terminal: a directed pass, blink timer checks
// and random command streams under several register settings. Each result word is checked.
// Depends on stt_pkg, stt_if and the scrolling_text_terminal RTL.
module scrolling_text_terminal_test;
    import stt_pkg::*;

    localparam int ROWS         = 24;
    localparam int COLS         = 40;
    localparam int CELLS        = ROWS * COLS;
    localparam int SETTLE_WAIT  = 6;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int MAX_PRINTED  = 40;

    typedef struct packed {
        logic              echo_valid;
        logic [CHAR_W-1:0] echo_char;
        logic              cell_valid;
        logic [4:0]        cell_row;
        logic [5:0]        cell_col;
        logic [CHAR_W-1:0] cell_char;
        logic              scrolled;
        logic              cursor_visible;
        logic [4:0]        cursor_row;
        logic [5:0]        cursor_col;
        logic [CHAR_W-1:0] read_char;
    } term_result_t;

    logic             clk = 1'b0;
    logic             rst_n;
    logic             cfg_we;
    reg_idx_t         cfg_index;
    logic [CFG_W-1:0] cfg_data;

    stt_cmd_if #(.SCREEN_ROWS(ROWS), .SCREEN_COLS(COLS)) cmd_ch ();
    stt_res_if #(.SCREEN_ROWS(ROWS), .SCREEN_COLS(COLS)) res_ch ();

    scrolling_text_terminal #(
        .SCREEN_ROWS(ROWS),
        .SCREEN_COLS(COLS)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd_ch),
        .res       (res_ch)
    );

    // Mirror of the terminal state
    logic [CHAR_W-1:0]  screen_mirror [CELLS];
    int                 row_pos;
    int                 col_pos;
    int                 newline_count;
    logic               cursor_shown;
    logic [BLINK_W-1:0] blink_count;
    logic [BLINK_W-1:0] blink_period;
    logic [NL_W-1:0]    newline_limit;

    term_result_t       pending_results [$];
    term_result_t       want;
    int                 errors = 0;
    int                 cycles = 0;
    bit                 idle_on = 1'b1;

    // Clock
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Give up on a hung run
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("[scrolling_text_terminal] ERROR");
            $finish;
        end
    end

    function automatic void blank_mirror();
        for (int i = 0; i < CELLS; i++)
            screen_mirror[i] = CHAR_SPACE;
    endfunction

    // Move to the start of the next row; scroll up past the bottom row
    function automatic bit advance_row();
        row_pos++;
        col_pos = 0;
        if (row_pos >= ROWS)
        begin
            for (int i = 0; i < CELLS - COLS; i++)
                screen_mirror[i] = screen_mirror[i + COLS];
            for (int i = CELLS - COLS; i < CELLS; i++)
                screen_mirror[i] = CHAR_SPACE;
            row_pos = ROWS - 1;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // Apply one command word to the mirror and return the result word it causes
    function automatic term_result_t apply_command(cmd_t op, logic [CHAR_W-1:0] code,
                                                   logic [4:0] rr, logic [5:0] rc);
        term_result_t r;
        logic [CHAR_W-1:0] ch;
        bit keep;
        r = '0;
        ch = code;
        case (op)
            CMD_WRITE:
            begin
                cursor_shown = 1'b0;
                keep = !(ch == CHAR_DEL || (ch < CHAR_SPACE && ch != CHAR_CR && ch != CHAR_LF));
                if (keep && ch == CHAR_CR)
                    ch = CHAR_LF;
                if (keep)
                begin
                    if (ch == CHAR_LF)
                    begin
                        if (newline_count >= newline_limit)
                            keep = 1'b0;
                        else
                            newline_count++;
                    end
                    else
                        newline_count = 0;
                end
                if (keep)
                begin
                    r.echo_valid = 1'b1;
                    r.echo_char = ch;
                    if (ch == CHAR_LF)
                    begin
                        // Blank the rest of the line, then move down
                        while (col_pos < COLS)
                        begin
                            screen_mirror[row_pos * COLS + col_pos] = CHAR_SPACE;
                            col_pos++;
                        end
                        r.scrolled = advance_row();
                    end
                    else
                    begin
                        if (col_pos >= COLS)
                            r.scrolled = advance_row();
                        screen_mirror[row_pos * COLS + col_pos] = ch;
                        r.cell_valid = 1'b1;
                        r.cell_row = row_pos[4:0];
                        r.cell_col = col_pos[5:0];
                        r.cell_char = ch;
                        col_pos++;
                    end
                end
            end
            CMD_TICK:
            begin
                blink_count = blink_count + BLINK_W'(1);
                if (blink_count >= blink_period)
                begin
                    blink_count = '0;
                    cursor_shown = !cursor_shown;
                end
            end
            CMD_CLEAR:
            begin
                blank_mirror();
                row_pos = 0;
                col_pos = 0;
            end
            default:
            begin
                if (rr < ROWS && rc < COLS)
                    r.read_char = screen_mirror[rr * COLS + rc];
            end
        endcase
        r.cursor_visible = cursor_shown;
        r.cursor_row = row_pos[4:0];
        r.cursor_col = col_pos[5:0];
        return r;
    endfunction

    // Mostly no gap, some short ones, a few long ones; none when idle_on is clear
    function automatic int pick_gap();
        int roll;
        if (!idle_on)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return 0;
        if (roll < 95)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic report_error(string what);
        if (errors < MAX_PRINTED)
            $display("mismatch at cycle %0d: %s", cycles, what);
        errors++;
    endtask

    task automatic check_field(string name, logic [7:0] got, logic [7:0] exp_val);
        if (got !== exp_val)
            report_error($sformatf("%s got %0h want %0h", name, got, exp_val));
    endtask

    // Predict on every accepted command word
    always @(posedge clk)
    begin
        if (rst_n && cmd_ch.valid && cmd_ch.ready)
            pending_results.push_back(apply_command(cmd_t'(cmd_ch.command), cmd_ch.char_code,
                                                    cmd_ch.read_row, cmd_ch.read_col));
    end

    // Check every accepted result word against the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            if (pending_results.size() == 0)
                report_error("result word with nothing predicted");
            else
            begin
                want = pending_results.pop_front();
                check_field("echo_valid", 8'(res_ch.echo_valid), 8'(want.echo_valid));
                check_field("echo_char", 8'(res_ch.echo_char), 8'(want.echo_char));
                check_field("cell_valid", 8'(res_ch.cell_valid), 8'(want.cell_valid));
                check_field("cell_row", 8'(res_ch.cell_row), 8'(want.cell_row));
                check_field("cell_col", 8'(res_ch.cell_col), 8'(want.cell_col));
                check_field("cell_char", 8'(res_ch.cell_char), 8'(want.cell_char));
                check_field("scrolled", 8'(res_ch.scrolled), 8'(want.scrolled));
                check_field("cursor_visible", 8'(res_ch.cursor_visible),
                            8'(want.cursor_visible));
                check_field("cursor_row", 8'(res_ch.cursor_row), 8'(want.cursor_row));
                check_field("cursor_col", 8'(res_ch.cursor_col), 8'(want.cursor_col));
                check_field("read_char", 8'(res_ch.read_char), 8'(want.read_char));
            end
        end
    end

    // Stall the result side in random bursts
    initial
    begin : result_stall
        int burst;
        int stall;
        res_ch.ready = 1'b0;
        @(negedge clk);
        forever
        begin
            res_ch.ready <= 1'b1;
            burst = $urandom_range(1, 12);
            repeat (burst) @(negedge clk);
            stall = pick_gap();
            if (stall > 0)
            begin
                res_ch.ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
        end
    end

    // Send one command word; hold it until taken
    task automatic send_word(cmd_t op, logic [CHAR_W-1:0] code, logic [4:0] rr,
                             logic [5:0] rc);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            cmd_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        cmd_ch.valid <= 1'b1;
        cmd_ch.command <= op;
        cmd_ch.char_code <= code;
        cmd_ch.read_row <= rr;
        cmd_ch.read_col <= rc;
        @(posedge clk);
        while (!cmd_ch.ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic send_char(logic [CHAR_W-1:0] code);
        send_word(CMD_WRITE, code, 5'($urandom_range(0, 31)), 6'($urandom_range(0, 63)));
    endtask

    task automatic send_read(logic [4:0] rr, logic [5:0] rc);
        send_word(CMD_READ, 7'($urandom_range(0, 127)), rr, rc);
    endtask

    task automatic send_tick();
        send_word(CMD_TICK, 7'($urandom_range(0, 127)), 5'($urandom_range(0, 31)),
                  6'($urandom_range(0, 63)));
    endtask

    task automatic send_clear();
        send_word(CMD_CLEAR, 7'($urandom_range(0, 127)), 5'($urandom_range(0, 31)),
                  6'($urandom_range(0, 63)));
    endtask

    // Drop valid and wait until every predicted word has come back
    task automatic wait_idle();
        cmd_ch.valid <= 1'b0;
        @(negedge clk);
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (SETTLE_WAIT) @(negedge clk);
    endtask

    task automatic write_reg(reg_idx_t idx, logic [CFG_W-1:0] value);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        if (idx == REG_BLINK_PERIOD)
            blink_period = value;
        else
            newline_limit = value[NL_W-1:0];
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    // Character filtering, CR to LF, newline suppression, reads, tick and clear
    task automatic test_directed_chars();
        send_read(5'd0, 6'd0);
        send_read(5'(ROWS - 1), 6'(COLS - 1));
        send_char(7'h00);
        send_char(7'h1F);
        send_char(CHAR_DEL);
        send_char(CHAR_SPACE);
        send_char(7'h7E);
        send_char(7'h41);
        send_char(CHAR_CR);
        send_char(CHAR_LF);
        send_char(CHAR_LF);
        send_char(7'h5A);
        send_read(5'd0, 6'd1);
        send_read(5'd0, 6'd3);
        send_read(5'd31, 6'd63);
        send_read(5'd0, 6'(COLS));
        send_read(5'(ROWS), 6'd0);
        send_tick();
        send_clear();
        send_read(5'd0, 6'd1);
    endtask

    // Blink timer: period one, period lowered below the elapsed count, widest period
    task automatic test_blink();
        wait_idle();
        write_reg(REG_BLINK_PERIOD, 16'd1);
        repeat (3) send_tick();
        wait_idle();
        write_reg(REG_BLINK_PERIOD, 16'd40);
        repeat (12) send_tick();
        wait_idle();
        write_reg(REG_BLINK_PERIOD, 16'd5);
        repeat (3) send_tick();
        wait_idle();
        write_reg(REG_BLINK_PERIOD, 16'hFFFF);
        repeat (4) send_tick();
    endtask

    // One random word, or a burst of newlines
    task automatic send_random_word();
        int roll;
        int burst;
        roll = $urandom_range(0, 999);
        if (roll < 600)
            send_char(7'($urandom_range(32, 126)));
        else if (roll < 680)
        begin
            burst = $urandom_range(1, 4);
            repeat (burst) send_char($urandom_range(0, 1) ? CHAR_LF : CHAR_CR);
        end
        else if (roll < 720)
        begin
            burst = $urandom_range(0, 32);
            send_char(burst == 32 ? CHAR_DEL : 7'(burst));
        end
        else if (roll < 850)
        begin
            if ($urandom_range(0, 9) != 0)
                send_read(5'($urandom_range(0, ROWS - 1)), 6'($urandom_range(0, COLS - 1)));
            else
                send_read(5'($urandom_range(0, 31)), 6'($urandom_range(0, 63)));
        end
        else if (roll < 997)
            send_tick();
        else
            send_clear();
    endtask

    task automatic test_random_traffic(int n_words, logic [CFG_W-1:0] period,
                                       logic [NL_W-1:0] limit, bit with_idle, bit mid_drain);
        wait_idle();
        write_reg(REG_BLINK_PERIOD, period);
        write_reg(REG_NEWLINE_LIMIT, {{(CFG_W - NL_W){1'b0}}, limit});
        idle_on = with_idle;
        for (int i = 0; i < n_words; i++)
        begin
            // Hold the sender until the pipe runs dry once
            if (mid_drain && i == n_words / 2)
                wait_idle();
            send_random_word();
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = REG_BLINK_PERIOD;
        cfg_data = '0;
        cmd_ch.valid = 1'b0;
        cmd_ch.command = CMD_WRITE;
        cmd_ch.char_code = '0;
        cmd_ch.read_row = '0;
        cmd_ch.read_col = '0;
        blank_mirror();
        row_pos = 0;
        col_pos = 0;
        newline_count = 0;
        cursor_shown = 1'b0;
        blink_count = '0;
        blink_period = BLINK_PERIOD_RST;
        newline_limit = NEWLINE_LIMIT_RST;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_directed_chars();
        test_blink();
        test_random_traffic(300, 16'd3, 2'd1, 1'b1, 1'b1);
        test_random_traffic(300, 16'hFFFF, 2'd3, 1'b1, 1'b0);
        test_random_traffic(300, 16'd1, 2'd2, 1'b0, 1'b0);
        test_random_traffic(300, 16'd9, 2'd3, 1'b1, 1'b0);
        test_random_traffic(300, 16'd500, 2'd1, 1'b1, 1'b0);
        wait_idle();

        if (errors == 0)
            $display("[scrolling_text_terminal] OK");
        else
            $display("[scrolling_text_terminal] ERROR");
        $finish;
    end

endmodule

/* scrolling_text_terminal.f */
+incdir+rtl
rtl/stt_pkg.sv
rtl/stt_if.sv
rtl/stt_state.sv
rtl/stt_screen.sv
rtl/scrolling_text_terminal.sv
rtl/stt_checker.sv
bench/scrolling_text_terminal_test.sv
